FILE: src/join_shortest_queue_dispatch_macros.svh
// assertion macros for the join shortest queue dispatcher
// no dependencies
`ifndef JOIN_SHORTEST_QUEUE_DISPATCH_MACROS_SVH
`define JOIN_SHORTEST_QUEUE_DISPATCH_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define JSQ_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jsq assertion failed");
// next-cycle implication
`define JSQ_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jsq assertion failed");
`endif

FILE: src/jsq_pkg.sv
// shared types and constants for the join shortest queue dispatcher
// no dependencies
package jsq_pkg;
	localparam int TimeW = 48;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	typedef struct packed {
		logic [31:0] arrival_time;
		logic [31:0] service_time;
		logic        new_case;
	} jsq_in_t;

	typedef struct packed {
		logic [3:0]       queue_index;
		logic [TimeW-1:0] finish_time;
		logic [TimeW-1:0] max_finish;
		logic             overflow;
	} jsq_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture job, clear if new case
		logic ret_rd;    // issue head read for retire queue
		logic ret_chk;   // compare head with arrival
		logic ret_next;  // advance retire queue
		logic srch_init; // start minimum search
		logic srch_step; // one search compare
		logic place;     // write job and finish time
		logic report;    // drive result strobe
	} jsq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ret_pop;   // head retired, read next head
		logic ret_last;  // retire pointer at last queue
		logic srch_last; // search at last in-use queue
	} jsq_sts_t;
endpackage

FILE: src/jsq_datapath.sv
// datapath: queue state, pending finish memory, retire walk, minimum search
// depends on jsq_pkg
module jsq_datapath import jsq_pkg::*; #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [4:0] cfg_data,
	input  jsq_in_t  job,
	input  jsq_cmd_t cmd,
	output jsq_sts_t sts,
	output logic     strobe,
	output jsq_out_t result
);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int DW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW = $clog2(MD);

	logic [TimeW-1:0] mem [MD];
	logic [TimeW-1:0] rd_q;
	logic [DW-1:0]    head_q  [NUM_QUEUES];
	logic [CW-1:0]    count_q [NUM_QUEUES];
	logic [TimeW-1:0] last_q  [NUM_QUEUES];
	logic [TimeW-1:0] max_q;
	logic [4:0]       in_use_q;
	logic [31:0]      arr_q, svc_q;
	logic [QW-1:0]    rq_q, sq_q, best_q;
	logic [QW-1:0]    used_m1;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [DW:0]      slot_sum;
	logic [DW-1:0]    slot;
	logic [TimeW:0]   fin_sum;
	logic [TimeW-1:0] start_t, fin_t;
	logic             full;

	// in-use count clamped to 1..NUM_QUEUES, less one
	always_comb begin
		if (in_use_q == 5'd0)
			used_m1 = '0;
		else if (32'(in_use_q) > NUM_QUEUES)
			used_m1 = QW'(NUM_QUEUES - 1);
		else
			used_m1 = QW'(in_use_q - 5'd1);
	end

	assign rd_addr  = AW'(rq_q) * AW'(QUEUE_DEPTH) + AW'(head_q[rq_q]);
	// ring slot after the last pending entry, wrapped at the ring depth
	assign slot_sum = (DW+1)'(head_q[best_q]) + (DW+1)'(count_q[best_q]);
	assign slot     = (32'(slot_sum) >= QUEUE_DEPTH) ? DW'(32'(slot_sum) - QUEUE_DEPTH)
		: DW'(slot_sum);
	assign wr_addr  = AW'(best_q) * AW'(QUEUE_DEPTH) + AW'(slot);
	assign full     = 32'(count_q[best_q]) >= QUEUE_DEPTH;
	assign start_t  = (last_q[best_q] > TimeW'(arr_q)) ? last_q[best_q] : TimeW'(arr_q);
	assign fin_sum  = {1'b0, start_t} + (TimeW+1)'(svc_q);
	assign fin_t    = fin_sum[TimeW] ? TimeMax : fin_sum[TimeW-1:0];

	assign sts.ret_pop   = (count_q[rq_q] != '0) && (rd_q <= TimeW'(arr_q));
	assign sts.ret_last  = (32'(rq_q) == NUM_QUEUES - 1);
	assign sts.srch_last = (sq_q >= used_m1);

	always_ff @(posedge clk) begin
		if (cmd.ret_rd)
			rd_q <= mem[rd_addr];
		if (cmd.place && !full)
			mem[wr_addr] <= fin_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
				last_q[i]  <= '0;
			end
			max_q    <= '0;
			in_use_q <= 5'd16;
			strobe   <= 1'b0;
			rq_q     <= '0;
			sq_q     <= '0;
			best_q   <= '0;
		end else begin
			strobe <= cmd.report;
			if (cfg_we)
				in_use_q <= cfg_data;
			if (cmd.load) begin
				arr_q <= job.arrival_time;
				svc_q <= job.service_time;
				rq_q  <= '0;
				if (job.new_case) begin
					for (int i = 0; i < NUM_QUEUES; i++) begin
						head_q[i]  <= '0;
						count_q[i] <= '0;
						last_q[i]  <= '0;
					end
					max_q <= '0;
				end
			end
			if (cmd.ret_chk && sts.ret_pop) begin
				head_q[rq_q]  <= (32'(head_q[rq_q]) == QUEUE_DEPTH - 1) ? '0
					: head_q[rq_q] + 1'b1;
				count_q[rq_q] <= count_q[rq_q] - 1'b1;
			end
			if (cmd.ret_next)
				rq_q <= rq_q + 1'b1;
			if (cmd.srch_init) begin
				sq_q   <= '0;
				best_q <= '0;
			end
			if (cmd.srch_step) begin
				if (count_q[sq_q] < count_q[best_q])
					best_q <= sq_q;
				if (!sts.srch_last)
					sq_q <= sq_q + 1'b1;
			end
			if (cmd.place) begin
				result.queue_index <= 4'(best_q);
				result.overflow    <= full;
				if (full) begin
					result.finish_time <= '0;
					result.max_finish  <= max_q;
				end else begin
					count_q[best_q]    <= count_q[best_q] + 1'b1;
					last_q[best_q]     <= fin_t;
					result.finish_time <= fin_t;
					result.max_finish  <= (fin_t > max_q) ? fin_t : max_q;
					if (fin_t > max_q)
						max_q <= fin_t;
				end
			end
		end
	end
endmodule

FILE: src/jsq_ctrl.sv
// controller state machine sequencing retire walk, search and placement
// depends on jsq_pkg and the macros header
`include "join_shortest_queue_dispatch_macros.svh"
module jsq_ctrl import jsq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  jsq_sts_t sts,
	output logic     busy,
	output jsq_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CHK, S_SINIT, S_SRCH, S_PLACE, S_RPT
	} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.ret_rd    = (state_q == S_RD);
		cmd.ret_chk   = (state_q == S_CHK);
		cmd.ret_next  = (state_q == S_CHK) && !sts.ret_pop && !sts.ret_last;
		cmd.srch_init = (state_q == S_SINIT);
		cmd.srch_step = (state_q == S_SRCH);
		cmd.place     = (state_q == S_PLACE);
		cmd.report    = (state_q == S_PLACE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_RD;
					busy    <= 1'b1;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (sts.ret_pop)
						state_q <= S_RD;
					else if (sts.ret_last)
						state_q <= S_SINIT;
					else
						state_q <= S_RD;
				end
				S_SINIT: state_q <= S_SRCH;
				S_SRCH: if (sts.srch_last) state_q <= S_PLACE;
				S_PLACE: state_q <= S_RPT;
				S_RPT: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	`JSQ_ASSERT_IMP(a_idle_not_busy, clk, arst_n, state_q == S_IDLE, !busy)
	`JSQ_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`JSQ_ASSERT_NXT(a_place_report, clk, arst_n, state_q == S_PLACE, state_q == S_RPT)
endmodule

FILE: src/join_shortest_queue_dispatch.sv
// top level of the join shortest queue dispatcher
// depends on jsq_pkg, jsq_ctrl and jsq_datapath
//
// A job is taken when start is high and busy low; one result follows with
// strobe high for a single cycle, which the receiver cannot stall. A job
// first reads each queue's head entry (each queue reads its head once, plus
// once per retired job), then searches the in-use queues for the minimum,
// places the job and reports the result. The single read port of the
// pending finish memory sets the retire walk pace. new_case clears queue
// state in the capture cycle; queues_in_use is written through cfg_we /
// cfg_data.
module join_shortest_queue_dispatch import jsq_pkg::*; #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  jsq_in_t  job,
	output logic     strobe,
	output jsq_out_t result,
	input  logic     cfg_we,
	input  logic [4:0] cfg_data
);
	jsq_cmd_t cmd;
	jsq_sts_t sts;

	// sequencing of one transaction
	jsq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	// queue state and arithmetic
	jsq_datapath #(.NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.job(job), .cmd(cmd), .sts(sts), .strobe(strobe), .result(result)
	);
endmodule

FILE: bench/join_shortest_queue_dispatch_tb.sv
// self-checking bench for the join shortest queue dispatcher
// depends on jsq_pkg and join_shortest_queue_dispatch
`timescale 1ns / 100ps

module join_shortest_queue_dispatch_tb;
	import jsq_pkg::*;

	localparam int NQ = 16;
	localparam int QD = 64;
	localparam longint CycleLimit = 1500000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	jsq_in_t  job = '0;
	logic     strobe;
	jsq_out_t result;
	logic     cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;

	join_shortest_queue_dispatch #(.NUM_QUEUES(NQ), .QUEUE_DEPTH(QD)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .job(job),
		.strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the dispatcher state
	logic [47:0] ring_finish [NQ][QD];
	int          ring_head [NQ];
	int          ring_count [NQ];
	logic [47:0] tail_finish [NQ];
	logic [47:0] case_max;
	logic [4:0]  active_cfg;

	jsq_in_t  job_queue [$];
	jsq_out_t dispatch_expected [$];
	int       send_idle_pct = 0;
	int       errors = 0;
	longint   cycles = 0;
	bit       stim_done = 0;
	bit       hold_sender = 0;
	logic [4:0] cfg_set [6] = '{5'd4, 5'd0, 5'd31, 5'd1, 5'd9, 5'd16};

	function automatic void clear_shadow();
		for (int q = 0; q < NQ; q++) begin
			ring_head[q] = 0;
			ring_count[q] = 0;
			tail_finish[q] = '0;
		end
		case_max = '0;
	endfunction

	// predict one dispatch decision and update the shadow
	function automatic jsq_out_t predict_dispatch(jsq_in_t j);
		jsq_out_t r;
		int used, best, slot;
		logic [48:0] fin;
		logic [47:0] st;
		if (j.new_case) clear_shadow();
		for (int q = 0; q < NQ; q++)
			while (ring_count[q] > 0 && ring_finish[q][ring_head[q]] <= {16'b0, j.arrival_time}) begin
				ring_head[q] = (ring_head[q] + 1) % QD;
				ring_count[q]--;
			end
		used = (active_cfg == 0) ? 1 : (active_cfg > NQ ? NQ : int'(active_cfg));
		best = 0;
		for (int q = 1; q < used; q++)
			if (ring_count[q] < ring_count[best]) best = q;
		r.queue_index = best[3:0];
		if (ring_count[best] >= QD) begin
			r.finish_time = '0;
			r.max_finish = case_max;
			r.overflow = 1'b1;
			return r;
		end
		st = (tail_finish[best] > {16'b0, j.arrival_time}) ? tail_finish[best]
			: {16'b0, j.arrival_time};
		fin = {1'b0, st} + {17'b0, j.service_time};
		if (fin > {1'b0, TimeMax}) fin = {1'b0, TimeMax};
		slot = (ring_head[best] + ring_count[best]) % QD;
		ring_finish[best][slot] = fin[47:0];
		ring_count[best]++;
		tail_finish[best] = fin[47:0];
		if (fin[47:0] > case_max) case_max = fin[47:0];
		r.finish_time = fin[47:0];
		r.max_finish = case_max;
		r.overflow = 1'b0;
		return r;
	endfunction

	// driver: one transaction per accept edge, random gaps
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (start && !busy) begin
			dispatch_expected.push_back(predict_dispatch(job));
		end
		if (start && busy) begin
			// hold current transaction
		end else if (job_queue.size() > 0 && !hold_sender && arst_n
				&& $urandom_range(99) >= send_idle_pct) begin
			job <= job_queue.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		jsq_out_t e;
		if (strobe) begin
			if (dispatch_expected.size() == 0) begin
				$display("%0t unexpected result %p", $time, result);
				errors = errors + 1;
			end else begin
				e = dispatch_expected.pop_front();
				if (result.queue_index !== e.queue_index) begin
					$display("%0t queue_index exp %0d got %0d", $time, e.queue_index,
						result.queue_index);
					errors = errors + 1;
				end
				if (result.finish_time !== e.finish_time) begin
					$display("%0t finish_time exp %0d got %0d", $time, e.finish_time,
						result.finish_time);
					errors = errors + 1;
				end
				if (result.max_finish !== e.max_finish) begin
					$display("%0t max_finish exp %0d got %0d", $time, e.max_finish,
						result.max_finish);
					errors = errors + 1;
				end
				if (result.overflow !== e.overflow) begin
					$display("%0t overflow exp %0d got %0d", $time, e.overflow,
						result.overflow);
					errors = errors + 1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk)
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end

	function automatic jsq_in_t mk_job(logic [31:0] a, logic [31:0] s, logic nc);
		jsq_in_t j;
		j.arrival_time = a;
		j.service_time = s;
		j.new_case = nc;
		return j;
	endfunction

	// wait until everything queued has been dispatched and reported
	task automatic drain();
		while (job_queue.size() > 0 || start || dispatch_expected.size() > 0 || busy)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_queues(logic [4:0] v);
		drain();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		active_cfg = v;
		cfg_we <= 1'b0;
	endtask

	// a random case: mostly nondecreasing arrivals with occasional arbitrary ones, mostly short services
	task automatic random_case(int n);
		logic [31:0] t;
		logic [31:0] s;
		t = ($urandom_range(9) == 0) ? 32'hFFFF_0000 + $urandom_range(1000) : $urandom_range(500);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: s = $urandom;
				1: s = 32'hFFFF_FFFF;
				2: s = 0;
				default: s = $urandom_range(60);
			endcase
			if ($urandom_range(19) == 0) t = $urandom;   // noise: arbitrary arrival
			else if ($urandom_range(3) != 0) t = t + $urandom_range(8);
			job_queue.push_back(mk_job(t, s, i == 0));
		end
	endtask

	initial begin
		active_cfg = 5'd16;
		clear_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ties, decreasing arrival
		job_queue.push_back(mk_job(32'd0, 32'd0, 1'b0));
		job_queue.push_back(mk_job(32'd0, 32'hFFFF_FFFF, 1'b0));
		job_queue.push_back(mk_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		job_queue.push_back(mk_job(32'd5, 32'd3, 1'b0));
		job_queue.push_back(mk_job(32'hFFFF_FFFF, 32'd1, 1'b1));
		job_queue.push_back(mk_job(32'd10, 32'd100, 1'b1));
		job_queue.push_back(mk_job(32'd10, 32'd100, 1'b0));
		job_queue.push_back(mk_job(32'd110, 32'd0, 1'b0));
		job_queue.push_back(mk_job(32'd50, 32'd7, 1'b0));
		drain();

		// single queue fills up to overflow, retirement releases it
		write_queues(5'd1);
		for (int i = 0; i < QD + 3; i++)
			job_queue.push_back(mk_job(32'd1, 32'd10, i == 0));
		job_queue.push_back(mk_job(32'd2000, 32'd1, 1'b0));
		// shrink mid-case: queues beyond the count keep their jobs
		write_queues(5'd16);
		for (int i = 0; i < 12; i++) job_queue.push_back(mk_job(32'd3000, 32'd500, i == 0));
		write_queues(5'd3);
		for (int i = 0; i < 6; i++) job_queue.push_back(mk_job(32'd3100 + i, 32'd20, 1'b0));

		// random phases with varied queue counts and idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1 ? 70 : 0);
			for (int k = 0; k < 6; k++) begin
				write_queues(cfg_set[(k + ph) % 6]);
				for (int c = 0; c < 3; c++) random_case($urandom_range(10, 40));
				if (k == 2) begin
					// hold the sender until all results are back
					hold_sender = 1;
					while (dispatch_expected.size() > 0 || start) @(posedge clk);
					hold_sender = 0;
				end
			end
		end
		drain();
		if (errors == 0 && dispatch_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
